### sv/rlq_pkg.sv
// Shared types, codes and the level selection function for the run queue core.
// Used by rlq_link_table and three_level_linked_run_queue_core; no dependencies.
package rlq_pkg;

   // Operation codes carried on req_kind.
   typedef enum logic [2:0] {
      KIND_ENQUEUE = 3'd0,
      KIND_DEQUEUE = 3'd1,
      KIND_REMOVE  = 3'd2,
      KIND_ADJUST  = 3'd3,
      KIND_BOOST   = 3'd4
   } kind_type;

   // Result status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_EMPTY   = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_UPPER_BOUND  = 2'd0;
   localparam logic [1:0] CSR_MIDDLE_BOUND = 2'd1;

   // Nice range and bound reset values.
   localparam logic signed [7:0] NICE_MAX = 8'sd19;
   localparam logic signed [7:0] NICE_MIN = -8'sd20;
   localparam logic signed [5:0] UPPER_BOUND_RESET  = -6'sd10;
   localparam logic signed [5:0] MIDDLE_BOUND_RESET = 6'sd10;

   // Level codes.
   localparam logic [1:0] LEVEL_LOW  = 2'd0;
   localparam logic [1:0] LEVEL_MID  = 2'd1;
   localparam logic [1:0] LEVEL_HIGH = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACT,
      ST_INS_A,
      ST_INS_B,
      ST_BCHK
   } state_type;

   // Level that a nice value belongs to under the current bounds.
   function automatic logic [1:0] proper_level(input logic signed [5:0] nice,
                                                input logic signed [5:0] upper,
                                                input logic signed [5:0] middle);
      logic [1:0] lv;
      if (nice <= upper) begin
         lv = LEVEL_HIGH;
      end else if (nice <= middle) begin
         lv = LEVEL_MID;
      end else begin
         lv = LEVEL_LOW;
      end
      return lv;
   endfunction

endpackage

### sv/rlq_link_table.sv
// Next and previous link storage for the entries plus the head and tail sentinels.
// Depends on rlq_pkg; entry links live in memories, sentinel links in flip-flops.
module rlq_link_table
   import rlq_pkg::*;
#(
   parameter int NUM_ENTRIES = 64
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [$clog2(NUM_ENTRIES)-1:0]                rd_addr,
   output logic [$clog2(NUM_ENTRIES+6)-1:0]              rd_next,
   output logic [$clog2(NUM_ENTRIES+6)-1:0]              rd_prev,
   input  logic                                          next_we,
   input  logic [$clog2(NUM_ENTRIES+6)-1:0]              next_waddr,
   input  logic [$clog2(NUM_ENTRIES+6)-1:0]              next_wdata,
   input  logic                                          prev_we,
   input  logic [$clog2(NUM_ENTRIES+6)-1:0]              prev_waddr,
   input  logic [$clog2(NUM_ENTRIES+6)-1:0]              prev_wdata,
   output logic [2:0][$clog2(NUM_ENTRIES+6)-1:0]         head_next,
   output logic [2:0][$clog2(NUM_ENTRIES+6)-1:0]         tail_prev
);

   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int SW = $clog2(NUM_ENTRIES + 6);
   localparam logic [SW-1:0] BASE = SW'(NUM_ENTRIES);

   logic [SW-1:0] next_mem [NUM_ENTRIES];
   logic [SW-1:0] prev_mem [NUM_ENTRIES];
   logic [SW-1:0] rd_next_ff;
   logic [SW-1:0] rd_prev_ff;
   logic [2:0][SW-1:0] head_next_ff;
   logic [2:0][SW-1:0] tail_prev_ff;
   logic [SW-1:0] next_off;
   logic [SW-1:0] prev_off;
   logic [1:0]    next_sidx;
   logic [1:0]    prev_sidx;

   // Sentinel number of a slot at or above the entry range.
   assign next_off  = next_waddr - BASE;
   assign prev_off  = prev_waddr - BASE;
   assign next_sidx = next_off[2:1];
   assign prev_sidx = prev_off[2:1];

   // Entry link memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (next_we && (next_waddr < BASE)) begin
         next_mem[next_waddr[EW-1:0]] <= next_wdata;
      end
      if (prev_we && (prev_waddr < BASE)) begin
         prev_mem[prev_waddr[EW-1:0]] <= prev_wdata;
      end
      rd_next_ff <= next_mem[rd_addr];
      rd_prev_ff <= prev_mem[rd_addr];
   end

   // Sentinel links: each head points to its own tail after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < 3; l++) begin
            head_next_ff[l] <= BASE + SW'(2 * l + 1);
            tail_prev_ff[l] <= BASE + SW'(2 * l);
         end
      end else begin
         if (next_we && (next_waddr >= BASE) && (next_sidx != 2'd3)) begin
            head_next_ff[next_sidx] <= next_wdata;
         end
         if (prev_we && (prev_waddr >= BASE) && (prev_sidx != 2'd3)) begin
            tail_prev_ff[prev_sidx] <= prev_wdata;
         end
      end
   end

   assign rd_next   = rd_next_ff;
   assign rd_prev   = rd_prev_ff;
   assign head_next = head_next_ff;
   assign tail_prev = tail_prev_ff;

endmodule

### sv/three_level_linked_run_queue_core.sv
// Top level of the three level linked run queue core: sequencer and entry tables.
// Depends on rlq_pkg and rlq_link_table.
//
// Usage: an operation is transferred at a clock edge where start is high and busy
// is low; req_kind selects enqueue, dequeue, remove, adjust nice or boost, with
// req_entry and req_nice_delta as operands. Each operation gives one result,
// shown for one cycle with rsp_strobe high; the receiver cannot stall it.
// Remove, adjust nice and dequeue read the entry, then act; enqueue also links
// the entry in through the insert states unless refused. An out of range entry,
// an empty dequeue or an unknown kind is answered directly from idle. Boost walks
// the queues from low to high, reading each entry it visits (an entry moved up
// to a level not yet walked is visited again) and moving each one whose level no
// longer fits, one link table read and write pair per cycle in the sequencer.
// busy is high from a transfer that leaves idle until the strobe
// cycle, in which a new operation may already be transferred.
// The csr channel writes the two level bounds; it is always ready and is meant
// to be used only while the core is idle.
// Reset (synchronous) empties all queues, clears all nice values to zero and
// sets the bounds to -10 and 10.
module three_level_linked_run_queue_core
   import rlq_pkg::*;
#(
   parameter int NUM_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic [5:0]        req_entry,
   input  logic signed [6:0] req_nice_delta,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [5:0]        rsp_chosen_entry,
   output logic [1:0]        rsp_entry_level_out,
   output logic signed [5:0] rsp_nice_out,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_wdata
);

   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int SW = $clog2(NUM_ENTRIES + 6);
   localparam logic [SW-1:0] BASE = SW'(NUM_ENTRIES);

   state_type state_ff, state_in;
   logic [2:0]        kind_ff, kind_in;
   logic [5:0]        e_ff, e_in;
   logic signed [6:0] delta_ff, delta_in;
   logic [EW-1:0]     addr_ff, addr_in;
   logic [1:0]        lv_ff, lv_in;
   logic [1:0]        want_ff, want_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [SW-1:0]     nxt_ff, nxt_in;
   logic [SW-1:0]     first_ff, first_in;
   logic signed [5:0] nice_ff, nice_in;

   logic signed [5:0] upper_ff, middle_ff;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_chosen_ff, rsp_chosen_in;
   logic [1:0]        rsp_level_ff, rsp_level_in;
   logic signed [5:0] rsp_nice_ff, rsp_nice_in;

   // Entry tables.
   logic signed [5:0] nice_mem [NUM_ENTRIES];
   logic [1:0]        level_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] nice_vld_ff;
   logic [NUM_ENTRIES-1:0] queued_ff;
   logic signed [5:0] nice_rd_ff;
   logic              nice_vld_rd_ff;
   logic [1:0]        level_rd_ff;

   logic              nice_we;
   logic signed [5:0] nice_wdata;
   logic              level_we;
   logic              q_set, q_clr;

   // Link table ports.
   logic [SW-1:0]          rd_next, rd_prev;
   logic                   next_we, prev_we;
   logic [SW-1:0]          next_waddr, next_wdata, prev_waddr, prev_wdata;
   logic [2:0][SW-1:0]     head_next, tail_prev;

   // Combinational helpers.
   logic signed [5:0] nice_cur;
   logic [1:0]        want_cur;
   logic signed [7:0] nice_sum;
   logic signed [5:0] nice_sat;
   logic [SW-1:0]     e_slot;
   logic [SW-1:0]     a_slot;
   logic              e_range;

   rlq_link_table #(.NUM_ENTRIES(NUM_ENTRIES)) u_links (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (addr_ff),
      .rd_next    (rd_next),
      .rd_prev    (rd_prev),
      .next_we    (next_we),
      .next_waddr (next_waddr),
      .next_wdata (next_wdata),
      .prev_we    (prev_we),
      .prev_waddr (prev_waddr),
      .prev_wdata (prev_wdata),
      .head_next  (head_next),
      .tail_prev  (tail_prev)
   );

   // Configuration transfers are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= UPPER_BOUND_RESET;
         middle_ff <= MIDDLE_BOUND_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_UPPER_BOUND) begin
            upper_ff <= csr_wdata;
         end else if (csr_index == CSR_MIDDLE_BOUND) begin
            middle_ff <= csr_wdata;
         end
      end
   end

   // Nice and level memories with registered reads at the sequencer address.
   always_ff @(posedge clock) begin
      if (nice_we) begin
         nice_mem[addr_ff] <= nice_wdata;
      end
      if (level_we) begin
         level_mem[addr_ff] <= want_ff;
      end
      nice_rd_ff  <= nice_mem[addr_ff];
      level_rd_ff <= level_mem[addr_ff];
   end

   // Valid bits for nice values and queue membership bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         nice_vld_ff    <= '0;
         queued_ff      <= '0;
         nice_vld_rd_ff <= 1'b0;
      end else begin
         nice_vld_rd_ff <= nice_vld_ff[addr_ff];
         if (nice_we) begin
            nice_vld_ff[addr_ff] <= 1'b1;
         end
         if (q_set) begin
            queued_ff[addr_ff] <= 1'b1;
         end else if (q_clr) begin
            queued_ff[addr_ff] <= 1'b0;
         end
      end
   end

   // Sequencer state and operand registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      kind_ff       <= kind_in;
      e_ff          <= e_in;
      delta_ff      <= delta_in;
      addr_ff       <= addr_in;
      lv_ff         <= lv_in;
      want_ff       <= want_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      first_ff      <= first_in;
      nice_ff       <= nice_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_nice_ff   <= rsp_nice_in;
   end

   // Operand views: current nice, its level and the saturated adjustment.
   always_comb begin
      nice_cur = nice_vld_rd_ff ? nice_rd_ff : 6'sd0;
      want_cur = proper_level(nice_cur, upper_ff, middle_ff);
      nice_sum = 8'(nice_cur) + 8'(delta_ff);
      if (nice_sum > NICE_MAX) begin
         nice_sat = 6'(NICE_MAX);
      end else if (nice_sum < NICE_MIN) begin
         nice_sat = 6'(NICE_MIN);
      end else begin
         nice_sat = nice_sum[5:0];
      end
      e_slot  = SW'(e_ff);
      a_slot  = SW'(addr_ff);
      e_range = ({26'd0, req_entry} < 32'(NUM_ENTRIES));
   end

   // Next state, table writes and result.
   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      e_in       = e_ff;
      delta_in   = delta_ff;
      addr_in    = addr_ff;
      lv_in      = lv_ff;
      want_in    = want_ff;
      cur_in     = cur_ff;
      nxt_in     = nxt_ff;
      first_in   = first_ff;
      nice_in    = nice_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_nice_in   = rsp_nice_ff;
      nice_we    = 1'b0;
      nice_wdata = nice_sat;
      level_we   = 1'b0;
      q_set      = 1'b0;
      q_clr      = 1'b0;
      next_we    = 1'b0;
      next_waddr = rd_prev;
      next_wdata = rd_next;
      prev_we    = 1'b0;
      prev_waddr = rd_next;
      prev_wdata = rd_prev;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               e_in     = req_entry;
               delta_in = req_nice_delta;
               addr_in  = EW'(req_entry);
               rsp_status_in = STATUS_DONE;
               rsp_chosen_in = 6'd0;
               rsp_level_in  = LEVEL_LOW;
               rsp_nice_in   = 6'sd0;
               case (req_kind)
                  KIND_ENQUEUE, KIND_REMOVE, KIND_ADJUST: begin
                     rsp_chosen_in = req_entry;
                     if (e_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        if (req_kind == KIND_ENQUEUE) begin
                           rsp_status_in = STATUS_REFUSED;
                        end
                     end
                  end
                  KIND_DEQUEUE: begin
                     // Highest level whose tail sentinel points back at an entry.
                     if (tail_prev[2] < BASE) begin
                        addr_in  = tail_prev[2][EW-1:0];
                        lv_in    = LEVEL_HIGH;
                        state_in = ST_READ;
                     end else if (tail_prev[1] < BASE) begin
                        addr_in  = tail_prev[1][EW-1:0];
                        lv_in    = LEVEL_MID;
                        state_in = ST_READ;
                     end else if (tail_prev[0] < BASE) begin
                        addr_in  = tail_prev[0][EW-1:0];
                        lv_in    = LEVEL_LOW;
                        state_in = ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  KIND_BOOST: begin
                     lv_in    = LEVEL_LOW;
                     cur_in   = head_next[0];
                     state_in = ST_BCHK;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_ACT;
         end

         ST_ACT: begin
            state_in = ST_IDLE;
            case (kind_ff)
               KIND_ENQUEUE: begin
                  want_in = want_cur;
                  nice_in = nice_cur;
                  if (head_next[want_cur] == e_slot) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_REFUSED;
                     rsp_level_in  = want_cur;
                     rsp_nice_in   = nice_cur;
                  end else begin
                     if (queued_ff[addr_ff]) begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                     end
                     state_in = ST_INS_A;
                  end
               end
               KIND_REMOVE: begin
                  rsp_strobe_in = 1'b1;
                  rsp_nice_in   = nice_cur;
                  if (queued_ff[addr_ff]) begin
                     rsp_level_in = level_rd_ff;
                     next_we = 1'b1;
                     prev_we = 1'b1;
                     q_clr   = 1'b1;
                  end else begin
                     rsp_level_in = want_cur;
                  end
               end
               KIND_ADJUST: begin
                  nice_we       = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_nice_in   = nice_sat;
                  rsp_level_in  = proper_level(nice_sat, upper_ff, middle_ff);
               end
               KIND_DEQUEUE: begin
                  next_we = 1'b1;
                  prev_we = 1'b1;
                  q_clr   = 1'b1;
                  rsp_strobe_in = 1'b1;
                  rsp_chosen_in = 6'(addr_ff);
                  rsp_level_in  = lv_ff;
                  rsp_nice_in   = nice_cur;
               end
               default: begin
                  // Boost: move the entry if its level no longer fits.
                  nxt_in = rd_next;
                  if (want_cur != lv_ff) begin
                     want_in = want_cur;
                     next_we = 1'b1;
                     prev_we = 1'b1;
                     state_in = ST_INS_A;
                  end else begin
                     cur_in   = rd_next;
                     state_in = ST_BCHK;
                  end
               end
            endcase
         end

         ST_INS_A: begin
            // Entry links point at the old first entry and the head sentinel.
            first_in   = head_next[want_ff];
            next_we    = 1'b1;
            next_waddr = a_slot;
            next_wdata = head_next[want_ff];
            prev_we    = 1'b1;
            prev_waddr = a_slot;
            prev_wdata = BASE + SW'({want_ff, 1'b0});
            level_we   = 1'b1;
            q_set      = 1'b1;
            state_in   = ST_INS_B;
         end

         ST_INS_B: begin
            // Old first entry and the head sentinel point at the new entry.
            next_we    = 1'b1;
            next_waddr = BASE + SW'({want_ff, 1'b0});
            next_wdata = a_slot;
            prev_we    = 1'b1;
            prev_waddr = first_ff;
            prev_wdata = a_slot;
            if (kind_ff == KIND_BOOST) begin
               cur_in   = nxt_ff;
               state_in = ST_BCHK;
            end else begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_DONE;
               rsp_level_in  = want_ff;
               rsp_nice_in   = nice_ff;
            end
         end

         ST_BCHK: begin
            // End of a queue moves the walk to the next level, or ends the boost after the high level.
            if ((cur_ff == BASE + SW'({lv_ff, 1'b1})) || (cur_ff >= BASE)) begin
               if (lv_ff == LEVEL_HIGH) begin
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
               end else begin
                  lv_in  = lv_ff + 2'd1;
                  cur_in = head_next[lv_ff + 2'd1];
               end
            end else begin
               addr_in  = cur_ff[EW-1:0];
               state_in = ST_READ;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_entry    = rsp_chosen_ff;
   assign rsp_entry_level_out = rsp_level_ff;
   assign rsp_nice_out        = rsp_nice_ff;

endmodule
